### src/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Shared types and codes for the stack cells and the top level.
// ----------------------------------------------------------------------------
package mst_pkg;

	// Operation codes carried by the func field of a request.
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_UNDERFLOW = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	// One stack entry: the stored value and the running minimum at its depth.
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] minimum;
	} entry_t;

	// Shift controls broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

### src/mst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack cell
// One stack position. On a push it takes the entry of the cell above it, on a
// pop the entry of the cell below it, and otherwise it holds.
// ----------------------------------------------------------------------------
module mst_cell
	import mst_pkg::*;
(
	input  logic       clk,
	input  shift_ctl_t ctl,
	input  entry_t     from_above,
	input  entry_t     from_below,
	output entry_t     entry
);

	entry_t entry_q;

	// Shift the entry down on a push and up on a pop.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

### src/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack
// LIFO stack of signed 32-bit values that reports the smallest held value
// after every push or pop.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns its result on the
// done strobe in the following cycle. The stack is a chain of STACK_DEPTH
// cells that all shift by one position in the same cycle, so the top entry and
// its running minimum sit in the first cell and every request costs a single
// register update; busy therefore never rises. A push onto a full stack is
// dropped and flagged, a pop on an empty stack returns zeros and is flagged.
// ----------------------------------------------------------------------------
module min_tracking_stack
	import mst_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] min_value,
	output logic               is_empty,
	output logic [1:0]         status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          done_q;
	logic signed [31:0] popped_q;
	logic signed [31:0] min_q;
	logic          empty_q;
	status_t       status_q;

	entry_t     cell_entry [STACK_DEPTH];
	entry_t     push_entry;
	shift_ctl_t ctl;
	logic       accept;
	logic       is_full;
	logic       is_none;

	// No request ever stalls, so busy is tied low.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full = (count_q == CW'(STACK_DEPTH));
	assign is_none = (count_q == '0);

	// New top entry: the running minimum only falls when the value is smaller.
	always_comb begin
		push_entry.value   = value;
		push_entry.minimum = value;
		if (!is_none && !(value < cell_entry[0].minimum)) begin
			push_entry.minimum = cell_entry[0].minimum;
		end
	end

	// Shift controls for the cell chain.
	always_comb begin
		ctl.push = accept && (func == FUNC_PUSH) && !is_full;
		ctl.pop  = accept && (func == FUNC_POP) && !is_none;
	end

	// The chain of cells; the first cell holds the top of the stack.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t above;
		entry_t below;

		if (i == 0) begin : g_first
			assign above = push_entry;
		end else begin : g_inner_above
			assign above = cell_entry[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = cell_entry[i];
		end else begin : g_inner_below
			assign below = cell_entry[i+1];
		end

		mst_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.entry      (cell_entry[i])
		);
	end

	// Fill count tracks how many cells hold live entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Result payload, computed from the state before the shift.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (func == FUNC_PUSH) begin
				popped_q <= '0;
				empty_q  <= 1'b0;
				if (is_full) begin
					min_q    <= cell_entry[0].minimum;
					status_q <= STATUS_OVERFLOW;
				end else begin
					min_q    <= push_entry.minimum;
					status_q <= STATUS_OK;
				end
			end else begin
				if (is_none) begin
					popped_q <= '0;
					min_q    <= '0;
					empty_q  <= 1'b1;
					status_q <= STATUS_UNDERFLOW;
				end else begin
					popped_q <= cell_entry[0].value;
					status_q <= STATUS_OK;
					if (count_q == CW'(1)) begin
						min_q   <= '0;
						empty_q <= 1'b1;
					end else begin
						min_q   <= cell_entry[1].minimum;
						empty_q <= 1'b0;
					end
				end
			end
		end
	end

	assign done         = done_q;
	assign popped_value = popped_q;
	assign min_value    = min_q;
	assign is_empty     = empty_q;
	assign status       = status_q;

endmodule
